FILE: rtl/lif_pkg.sv
// Shared types, action codes and the B3/S23 rule for the life automaton step block.
`default_nettype none

package lif_pkg;

  // Default grid size
  localparam int DEF_COLUMNS = 64;
  localparam int DEF_ROWS    = 64;

  // Field widths of the item ports
  localparam int ACTION_W = 2;
  localparam int INDEX_W  = 6;

  // Action codes
  localparam logic [ACTION_W-1:0] ACT_WRITE   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_READ    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd2;

  // Rule thresholds on the live neighbor count
  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] SURVIVE_LOW = 4'd2;

  // Control states of the top level
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SWEEP
  } state_t;

  // Three vertically stacked old values of one column: rows r-1, r, r+1
  typedef struct packed {
    logic up;
    logic mid;
    logic down;
  } col_win_t;

  // B3/S23: birth on exactly three, survival on two or three
  function automatic logic life_rule(input logic alive, input logic [3:0] count);
    logic res;
    if (alive) begin
      res = (count >= SURVIVE_LOW) && (count <= BIRTH_COUNT);
    end else begin
      res = (count == BIRTH_COUNT);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lif_cell.sv
// One column cell of the generation sweep: holds two old rows, counts neighbors, applies the rule.
`default_nettype none

module lif_cell (
  input  wire                clk,
  input  wire                shift_en,
  input  wire                down_i,
  input  lif_pkg::col_win_t  left_i,
  input  lif_pkg::col_win_t  right_i,
  output lif_pkg::col_win_t  win_o,
  output logic               next_o
);

  logic       up_r;
  logic       up_nxt;
  logic       mid_r;
  logic       mid_nxt;
  logic [3:0] count;

  // rows move up by one as the next row arrives from the store
  always_comb begin
    up_nxt  = shift_en ? mid_r  : up_r;
    mid_nxt = shift_en ? down_i : mid_r;
  end

  always_ff @(posedge clk) begin
    up_r  <= up_nxt;
    mid_r <= mid_nxt;
  end

  // window seen by both neighbors
  assign win_o = '{up: up_r, mid: mid_r, down: down_i};

  // eight neighbors: three left, three right, above and below
  assign count = {3'b000, left_i.up}  + {3'b000, left_i.mid}  + {3'b000, left_i.down}
               + {3'b000, right_i.up} + {3'b000, right_i.mid} + {3'b000, right_i.down}
               + {3'b000, up_r}       + {3'b000, down_i};

  assign next_o = lif_pkg::life_rule(mid_r, count);

endmodule

`default_nettype wire

FILE: rtl/lif_cell_row.sv
// Row of column cells that turns a stream of old rows into new rows, borders kept.
`default_nettype none

module lif_cell_row #(
  parameter int COLUMNS = lif_pkg::DEF_COLUMNS
) (
  input  wire                clk,
  input  wire                shift_en,
  input  wire  [COLUMNS-1:0] down_i,
  output logic [COLUMNS-1:0] next_row_o
);

  lif_pkg::col_win_t win   [COLUMNS];
  lif_pkg::col_win_t left  [COLUMNS];
  lif_pkg::col_win_t right [COLUMNS];
  logic [COLUMNS-1:0] cell_next;

  for (genvar c = 0; c < COLUMNS; c++) begin : g_cell
    // neighbor windows, zero beyond the grid edge
    if (c == 0) begin : g_left_edge
      assign left[c] = '0;
    end else begin : g_left
      assign left[c] = win[c-1];
    end
    if (c == COLUMNS - 1) begin : g_right_edge
      assign right[c] = '0;
    end else begin : g_right
      assign right[c] = win[c+1];
    end

    lif_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .down_i   (down_i[c]),
      .left_i   (left[c]),
      .right_i  (right[c]),
      .win_o    (win[c]),
      .next_o   (cell_next[c])
    );

    // border columns keep their old value
    if (c == 0 || c == COLUMNS - 1) begin : g_border
      assign next_row_o[c] = win[c].mid;
    end else begin : g_inner
      assign next_row_o[c] = cell_next[c];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/life_automaton_step.sv
// Top level: cell grid store, item control and generation sweep of the life automaton.
//
//  channel   ports                                             handshake
//  --------  ------------------------------------------------  ---------------------------
//  input     in_action, in_column, in_row, in_write_value       start && !busy
//  result    out_read_value, out_done_res                       out_valid, one cycle
//
//  Write and unused actions stay in the idle state; the next item is taken right after.
//  A read passes through the registered row read, then picks the column in the read state.
//  In a generation the row store has one read and one write port
//  and the cell row consumes one grid row per cycle.
//  Reset clears the row valid bits at once; rows never written read as zero.
//  Results are strobed for one cycle and cannot be held off.
`default_nettype none

module life_automaton_step #(
  parameter int COLUMNS = lif_pkg::DEF_COLUMNS,
  parameter int ROWS    = lif_pkg::DEF_ROWS
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  output logic                          busy,
  input  wire  [lif_pkg::ACTION_W-1:0]  in_action,
  input  wire  [lif_pkg::INDEX_W-1:0]   in_column,
  input  wire  [lif_pkg::INDEX_W-1:0]   in_row,
  input  wire                           in_write_value,
  output logic                          out_valid,
  output logic                          out_read_value,
  output logic                          out_done_res
);

  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);

  lif_pkg::state_t    state_r;
  lif_pkg::state_t    state_nxt;
  logic [ROW_W-1:0]   data_row_r;
  logic [ROW_W-1:0]   data_row_nxt;
  logic [COL_W-1:0]   col_r;
  logic [COL_W-1:0]   col_nxt;
  logic               rd_ok_r;
  logic               rd_ok_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic               out_read_value_r;
  logic               out_read_value_nxt;

  logic [COLUMNS-1:0] mem [ROWS];
  logic [ROWS-1:0]    row_valid_r;
  logic [COLUMNS-1:0] rd_data_r;
  logic               rd_valid_r;
  logic [COLUMNS-1:0] rd_row;

  logic               accept;
  logic               in_ok;
  logic [ROW_W-1:0]   row_idx;
  logic [COL_W-1:0]   col_idx;
  logic [COLUMNS-1:0] col_onehot;
  logic               shift_en;
  logic [COLUMNS-1:0] new_row;

  logic [ROW_W-1:0]   raddr;
  logic               wen;
  logic [ROW_W-1:0]   waddr;
  logic [COLUMNS-1:0] wmask;
  logic [COLUMNS-1:0] wdata;

  // item decode
  assign busy       = (state_r != lif_pkg::ST_IDLE);
  assign accept     = start && !busy;
  assign in_ok      = (32'(in_column) < 32'(COLUMNS)) && (32'(in_row) < 32'(ROWS));
  assign row_idx    = ROW_W'(in_row);
  assign col_idx    = COL_W'(in_column);
  assign col_onehot = {{(COLUMNS-1){1'b0}}, 1'b1} << col_idx;

  // a row never written reads as zero
  assign rd_row = rd_valid_r ? rd_data_r : '0;

  lif_cell_row #(
    .COLUMNS (COLUMNS)
  ) u_cell_row (
    .clk        (clk),
    .shift_en   (shift_en),
    .down_i     (rd_row),
    .next_row_o (new_row)
  );

  // next state, store access and result
  always_comb begin
    state_nxt          = state_r;
    data_row_nxt       = data_row_r;
    col_nxt            = col_r;
    rd_ok_nxt          = rd_ok_r;
    out_valid_nxt      = 1'b0;
    out_read_value_nxt = 1'b0;
    shift_en           = 1'b0;
    raddr              = row_idx;
    wen                = 1'b0;
    waddr              = row_idx;
    wmask              = '0;
    wdata              = '0;
    case (state_r)
      lif_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_action)
            lif_pkg::ACT_WRITE: begin
              // first write into a row clears the rest of that row
              wen           = in_ok;
              wmask         = row_valid_r[row_idx] ? col_onehot : '1;
              wdata         = in_write_value ? col_onehot : '0;
              out_valid_nxt = 1'b1;
            end
            lif_pkg::ACT_READ: begin
              state_nxt = lif_pkg::ST_READ;
              col_nxt   = col_idx;
              rd_ok_nxt = in_ok;
            end
            lif_pkg::ACT_ADVANCE: begin
              state_nxt    = lif_pkg::ST_SWEEP;
              data_row_nxt = '0;
              raddr        = '0;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      lif_pkg::ST_READ: begin
        out_valid_nxt      = 1'b1;
        out_read_value_nxt = rd_ok_r & rd_row[col_r];
        state_nxt          = lif_pkg::ST_IDLE;
      end
      lif_pkg::ST_SWEEP: begin
        // old row data_row_r is on the read port; write back the row above it
        shift_en = 1'b1;
        if (data_row_r >= ROW_W'(2)) begin
          wen   = 1'b1;
          waddr = data_row_r - ROW_W'(1);
          wmask = '1;
          wdata = new_row;
        end
        if (data_row_r == ROW_W'(ROWS - 1)) begin
          state_nxt     = lif_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
        end else begin
          raddr        = data_row_r + ROW_W'(1);
          data_row_nxt = data_row_r + ROW_W'(1);
        end
      end
      default: begin
        state_nxt = lif_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lif_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      row_valid_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (wen) begin
        row_valid_r[waddr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    data_row_r       <= data_row_nxt;
    col_r            <= col_nxt;
    rd_ok_r          <= rd_ok_nxt;
    out_read_value_r <= out_read_value_nxt;
  end

  // row store: bit-masked write, registered read
  always_ff @(posedge clk) begin
    if (wen) begin
      for (int b = 0; b < COLUMNS; b++) begin
        if (wmask[b]) begin
          mem[waddr][b] <= wdata[b];
        end
      end
    end
    rd_data_r  <= mem[raddr];
    rd_valid_r <= row_valid_r[raddr];
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_done_res   = out_valid_r;

endmodule

`default_nettype wire

FILE: rtl/lif_checker.sv
// Port-level checks of the life automaton step timing, bound to the top level.
`default_nettype none

module lif_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          start,
  input wire                          busy,
  input wire [lif_pkg::ACTION_W-1:0]  in_action,
  input wire                          out_valid,
  input wire                          out_done_res
);

  logic accept;
  assign accept = start && !busy;

  // every result carries the done flag
  a_done_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_done_res)
    else $error("result without done flag");

  // a write or unused action answers in the next cycle and leaves the block free
  a_short_item: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action != lif_pkg::ACT_READ && in_action != lif_pkg::ACT_ADVANCE)
    |=> (out_valid && !busy))
    else $error("short item did not answer in one cycle");

  // a read holds the block in its read state, then answers
  a_read_timing: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action == lif_pkg::ACT_READ) |=> busy ##1 (out_valid && !busy))
    else $error("read item timing");

  // a generation occupies the block and gives no early result
  a_advance_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_action == lif_pkg::ACT_ADVANCE) |=> (busy && !out_valid))
    else $error("generation did not hold the block");

  // the block only becomes free again together with its result
  a_free_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("block freed without a result");

endmodule

bind life_automaton_step lif_checker u_lif_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_action    (in_action),
  .out_valid    (out_valid),
  .out_done_res (out_done_res)
);

`default_nettype wire
